// File: rtl/dism_pkg.sv
// Shared types and constants for the disjoint interval set merge block.
// Used by dism_front, dism_back and the top level disjoint_interval_set_merge.
package dism_pkg;

  localparam int MAX_INTERVALS_DEF = 16;
  localparam int VALUE_W = 31;
  localparam int OUT_COUNT_W = 5;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_LIST = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_ADD_OK   = 2'd0,
    STAT_ADD_FULL = 2'd1,
    STAT_LISTED   = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_CMP,
    ST_ADD_UPD,
    ST_LIST
  } state_t;

  // One classified request waiting between front and back.
  typedef struct packed {
    op_t               op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// File: rtl/dism_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on dism_pkg.
module dism_front
  import dism_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [VALUE_W-1:0]  in_value,
  output queue_head_t         head,
  input  logic                take
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop  = take && (cnt_r != 2'd0);

  always_comb begin
    cmd_in.op    = in_operation ? OP_LIST : OP_ADD;
    cmd_in.value = in_value;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_comb begin
    head.valid = (cnt_r != 2'd0);
    head.cmd   = mem_r[rd_ptr_r];
  end

endmodule

// File: rtl/dism_back.sv
// Back end: the interval table as a row of cells, the add and list sequencer
// and the result register. Depends on dism_pkg.
module dism_back
  import dism_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  queue_head_t            head,
  output logic                   take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [VALUE_W-1:0]     out_interval_start,
  output logic [VALUE_W-1:0]     out_interval_end,
  output logic [OUT_COUNT_W-1:0] out_interval_count,
  output logic                   out_last,
  output logic                   table_over
);

  localparam int M  = MAX_INTERVALS;
  localparam int CW = $clog2(M + 1);

  state_t state_r, state_nxt;

  logic [VALUE_W-1:0] start_r [M];
  logic [VALUE_W-1:0] end_r   [M];
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [VALUE_W-1:0] val_r;

  logic [M-1:0] vld, ge, isl, isr;
  logic [M-1:0] ge_r, isl_r, isr_r;
  logic         hit, ladj, radj;
  logic         hit_r, ladj_r, radj_r;

  logic out_free, emit_add, emit_list, list_empty, list_last, full;
  logic do_merge, do_ins;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [VALUE_W-1:0]     out_start_r, out_end_r;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                   out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  // Per-cell compare against the value; the table is sorted, so ge is a prefix.
  always_comb begin
    hit  = 1'b0;
    ladj = 1'b0;
    radj = 1'b0;
    for (int j = 0; j < M; j++) begin
      vld[j] = (CW'(j) < count_r);
      ge[j]  = vld[j] && (start_r[j] <= val_r);
    end
    for (int j = 0; j < M; j++) begin
      isl[j] = ge[j] && ((j == M - 1) ? 1'b1 : !ge[(j + 1) % M]);
      isr[j] = vld[j] && !ge[j] && ((j == 0) ? 1'b1 : ge[(j + M - 1) % M]);
      hit    = hit | (isl[j] && (end_r[j] >= val_r));
      ladj   = ladj | (isl[j] && (({1'b0, end_r[j]} + 32'd1) == {1'b0, val_r}));
      radj   = radj | (isr[j] && ({1'b0, start_r[j]} == ({1'b0, val_r} + 32'd1)));
    end
  end

  assign full       = (count_r == CW'(M));
  assign do_merge   = ladj_r && radj_r && !hit_r;
  assign do_ins     = !hit_r && !ladj_r && !radj_r && !full;
  assign list_empty = (count_r == '0);
  assign list_last  = (k_r == count_r - CW'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          state_nxt = (head.cmd.op == OP_LIST) ? ST_LIST : ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: state_nxt = ST_ADD_UPD;
      ST_ADD_UPD: if (out_free) state_nxt = ST_IDLE;
      ST_LIST: begin
        if (out_free && (list_empty || list_last)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    take      = (state_r == ST_IDLE) && head.valid;
    emit_add  = (state_r == ST_ADD_UPD) && out_free;
    emit_list = (state_r == ST_LIST) && out_free;
    count_nxt = count_r;
    if (emit_add && do_merge) count_nxt = count_r - CW'(1);
    else if (emit_add && do_ins) count_nxt = count_r + CW'(1);
    k_nxt = k_r;
    if (take) k_nxt = '0;
    else if (emit_list && !list_empty) k_nxt = k_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      if (emit_add || emit_list) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) val_r <= head.cmd.value;
    if (state_r == ST_ADD_CMP) begin
      ge_r   <= ge;
      isl_r  <= isl;
      isr_r  <= isr;
      hit_r  <= hit;
      ladj_r <= ladj;
      radj_r <= radj;
    end
    if (emit_add) begin
      out_status_r <= (!hit_r && !ladj_r && !radj_r && full) ? STAT_ADD_FULL : STAT_ADD_OK;
      out_start_r  <= '0;
      out_end_r    <= '0;
      out_count_r  <= OUT_COUNT_W'(count_nxt);
      out_last_r   <= 1'b1;
    end else if (emit_list) begin
      out_status_r <= list_empty ? STAT_EMPTY : STAT_LISTED;
      out_start_r  <= list_empty ? '0 : start_r[0];
      out_end_r    <= list_empty ? '0 : end_r[0];
      out_count_r  <= OUT_COUNT_W'(count_r);
      out_last_r   <= list_empty || list_last;
    end
  end

  // Table cells. A list walks the table by rotating the stored entries through
  // cell 0; after count steps the table is back in its original order.
  for (genvar j = 0; j < M; j++) begin : g_cell
    logic [VALUE_W-1:0] up_start, up_end, dn_start, dn_end;
    logic               dn_ge;
    if (j < M - 1) begin : g_up
      assign up_start = start_r[j+1];
      assign up_end   = end_r[j+1];
    end else begin : g_up_wrap
      assign up_start = start_r[0];
      assign up_end   = end_r[0];
    end
    if (j > 0) begin : g_dn
      assign dn_start = start_r[j-1];
      assign dn_end   = end_r[j-1];
      assign dn_ge    = ge_r[j-1];
    end else begin : g_dn_edge
      assign dn_start = start_r[0];
      assign dn_end   = end_r[0];
      assign dn_ge    = 1'b1;
    end

    always_ff @(posedge clk) begin
      if (emit_add) begin
        if (do_merge) begin
          if (isl_r[j]) begin
            end_r[j] <= up_end;
          end else if (!ge_r[j]) begin
            start_r[j] <= up_start;
            end_r[j]   <= up_end;
          end
        end else if (!hit_r && ladj_r) begin
          if (isl_r[j]) end_r[j] <= val_r;
        end else if (!hit_r && radj_r) begin
          if (isr_r[j]) start_r[j] <= val_r;
        end else if (do_ins && !ge_r[j]) begin
          if (dn_ge) begin
            start_r[j] <= val_r;
            end_r[j]   <= val_r;
          end else begin
            start_r[j] <= dn_start;
            end_r[j]   <= dn_end;
          end
        end
      end else if (emit_list && !list_empty && vld[j]) begin
        if (CW'(j) == count_r - CW'(1)) begin
          start_r[j] <= start_r[0];
          end_r[j]   <= end_r[0];
        end else begin
          start_r[j] <= up_start;
          end_r[j]   <= up_end;
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_interval_start = out_start_r;
  assign out_interval_end   = out_end_r;
  assign out_interval_count = out_count_r;
  assign out_last           = out_last_r;
  assign table_over         = (count_r > CW'(M));

endmodule

// File: rtl/disjoint_interval_set_merge.sv
// Top level of the disjoint interval set merge block.
// Instantiates dism_front and dism_back; depends on dism_pkg.
//
// Keeps up to MAX_INTERVALS sorted, disjoint intervals. An add request waits in
// the queue, is taken into the value register, is compared in parallel against
// every table cell, then updates the cells and loads the result register. The
// back end handles one request at a time, so no new request starts before the
// last is through. A list request streams one interval per cycle while the
// result side is not stalled, by rotating the table through its first cell,
// giving entry count results (or one empty status). A two-entry queue lets
// requests be accepted while the back end is busy or the result side is stalled.
module disjoint_interval_set_merge
  import dism_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic [VALUE_W-1:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [VALUE_W-1:0]     out_interval_start,
  output logic [VALUE_W-1:0]     out_interval_end,
  output logic [OUT_COUNT_W-1:0] out_interval_count,
  output logic                   out_last
);

  queue_head_t head;
  logic        take;
  logic        table_over;

  dism_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .head         (head),
    .take         (take)
  );

  dism_back #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .take               (take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_interval_start (out_interval_start),
    .out_interval_end   (out_interval_end),
    .out_interval_count (out_interval_count),
    .out_last           (out_last),
    .table_over         (table_over)
  );

  // The entry count never grows past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) !table_over)
    else $error("interval count exceeds table size");

  // An empty status is always a lone final result with a zero count.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_last && out_interval_count == '0))
    else $error("empty status without last or with nonzero count");

  // Add results carry no interval bounds and are always final.
  a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_ADD_OK || out_status == STAT_ADD_FULL))
      |-> (out_interval_start == '0 && out_interval_end == '0 && out_last))
    else $error("add result with interval bounds or without last");

endmodule
